/* hw/rtl/prks_pkg.sv */
// Package for the per-key shared rate shaper.
// Beat types, command classes, codes and fixed widths; no dependencies.
package prks_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] flow_key;
		logic [7:0]  conn_id;
		logic [47:0] sent_total;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [39:0] chunk_limit;
		logic        delayed;
		logic [31:0] delay_ms;
	} out_t;

	typedef enum logic [2:0] {
		K_PASS,
		K_BADCID,
		K_OPEN,
		K_PROG,
		K_CLOSE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		in_t   item;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	localparam logic [1:0] REQ_OPEN  = 2'd0;
	localparam logic [1:0] REQ_PROG  = 2'd1;
	localparam logic [1:0] REQ_CLOSE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_BUSY    = 2'd3;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_RATE   = 1'b1;

	localparam int RATE_W = 40;
	localparam int SENT_W = 48;
	localparam int TIME_W = 32;
	localparam int CNT_W  = 9;
	localparam int DIV_NW = 58;
	localparam int DIV_DW = 40;
	localparam int DIV_CW = 6;

	localparam logic [CNT_W-1:0]  CNT_MAX       = 9'd511;
	localparam logic [9:0]        MS_PER_S      = 10'd1000;
	localparam logic [31:0]       IDLE_DELAY_MS = 32'd100;
	localparam logic [RATE_W-1:0] RATE_RESET    = 40'd1048576;

endpackage

/* hw/rtl/prks_front.sv */
// Front end: takes one command beat and classifies it for the back end.
// Depends on prks_pkg.
module prks_front import prks_pkg::*; #(
	parameter int CONN_SLOTS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  in_t  item,
	input  logic enable,
	input  logic pop,
	output logic valid,
	output cmd_t cmd
);

	logic  valid_q;
	cmd_t  cmd_q;
	kind_t kind;

	always_comb begin
		kind = K_PASS;
		if (enable && item.req_type != 2'd3) begin
			if (32'(item.conn_id) >= CONN_SLOTS) begin
				kind = K_BADCID;
			end else begin
				case (item.req_type)
					REQ_OPEN:  kind = K_OPEN;
					REQ_PROG:  kind = K_PROG;
					REQ_CLOSE: kind = K_CLOSE;
					default:   kind = K_PASS;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cmd_q   <= '0;
		end else if (accept) begin
			valid_q   <= 1'b1;
			cmd_q     <= '{kind: kind, item: item};
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	assign valid = valid_q;
	assign cmd   = cmd_q;

endmodule

/* hw/rtl/prks_fifo.sv */
// Two-entry command queue between front and back ends.
// Depends on prks_pkg.
module prks_fifo import prks_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       wdata,
	input  logic       pop,
	output cmd_t       rdata,
	output fifo_stat_t stat
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				mem_q[wp_q] <= wdata;
				wp_q        <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign rdata      = mem_q[rp_q];
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

endmodule

/* hw/rtl/prks_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on prks_pkg.
module prks_div import prks_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              qbit;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= qbit ? DIV_DW'(trial - {1'b0, den_q}) : DIV_DW'(trial);
				num_q <= {num_q[DIV_NW-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

/* hw/rtl/prks_back.sv */
// Back end: connection and key tables, key search, share and delay math.
// Depends on prks_pkg and prks_div.
module prks_back import prks_pkg::*; #(
	parameter int KEY_SLOTS  = 64,
	parameter int CONN_SLOTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RATE_W-1:0] rate,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              pop,
	output logic              busy,
	output logic              done,
	output out_t              res
);

	localparam int KW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int KIW = $clog2(KEY_SLOTS + 1);
	localparam int CW  = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LOOK = 10'b0000000010,
		S_CONN = 10'b0000000100,
		S_SRCH = 10'b0000001000,
		S_CNT  = 10'b0000010000,
		S_CALC = 10'b0000100000,
		S_WSHR = 10'b0001000000,
		S_WQ   = 10'b0010000000,
		S_QCMP = 10'b0100000000,
		S_WDLY = 10'b1000000000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [KW-1:0]     slot_q;
	logic              new_q;
	logic [KIW-1:0]    srch_idx_q;
	logic              cmp_pend_q;
	logic [KW-1:0]     cmp_idx_q;
	logic              free_fnd_q;
	logic [KW-1:0]     free_q;
	logic [SENT_W-1:0] delta_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [RATE_W-1:0] share_q;
	logic [DIV_NW-1:0] dk_q;
	logic [DIV_NW-1:0] qk_q;
	out_t              res_q;
	logic              done_q;

	logic [CONN_SLOTS-1:0] conn_valid_q;
	logic [KEY_SLOTS-1:0]  key_valid_q;

	logic [KW-1:0]     cslot_mem [CONN_SLOTS];
	logic [SENT_W-1:0] csent_mem [CONN_SLOTS];
	logic [TIME_W-1:0] ctime_mem [CONN_SLOTS];
	logic [31:0]       hash_mem  [KEY_SLOTS];
	logic [CNT_W-1:0]  cnt_mem   [KEY_SLOTS];
	logic [KW-1:0]     cslot_rd;
	logic [SENT_W-1:0] csent_rd;
	logic [TIME_W-1:0] ctime_rd;
	logic [31:0]       hash_rd;
	logic [CNT_W-1:0]  cnt_rd;

	logic [CW-1:0]     cid_ix;
	logic [KW-1:0]     hash_addr;
	logic              hit;
	logic              free_any;
	logic [KW-1:0]     free_sel;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic [SENT_W-1:0] delta_n;
	logic [RATE_W-1:0] share_n;
	logic [31:0]       dly_n;
	logic              cs_we;
	logic              ct_we;
	logic              hash_we;
	logic              cnt_we;
	logic [CNT_W-1:0]  cnt_wd;

	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;

	prks_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	function automatic out_t mk(logic [1:0] st, logic [RATE_W-1:0] ch, logic [31:0] d);
		out_t r;
		r.status      = st;
		r.chunk_limit = ch;
		r.delayed     = (d != 32'd0);
		r.delay_ms    = d;
		return r;
	endfunction

	assign cid_ix    = CW'(cmd_q.item.conn_id);
	assign hash_addr = srch_idx_q[KW-1:0];
	assign hit       = key_valid_q[cmp_idx_q] && (hash_rd == cmd_q.item.flow_key);
	assign free_any  = free_fnd_q || !key_valid_q[cmp_idx_q];
	assign free_sel  = free_fnd_q ? free_q : cmp_idx_q;
	assign cnt_eff   = new_q ? '0 : cnt_rd;
	assign cnt_inc   = (cnt_eff == CNT_MAX) ? CNT_MAX : cnt_eff + 1'b1;
	assign cnt_dec   = (cnt_eff == '0) ? '0 : cnt_eff - 1'b1;
	assign delta_n   = (cmd_q.item.sent_total >= csent_rd) ?
		cmd_q.item.sent_total - csent_rd : '0;
	assign share_n   = (div_quo[RATE_W-1:0] == '0) ? RATE_W'(1) : div_quo[RATE_W-1:0];
	assign dly_n     = (div_quo > DIV_NW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_quo[31:0];

	always_comb begin
		cs_we   = 1'b0;
		ct_we   = 1'b0;
		hash_we = 1'b0;
		cnt_we  = 1'b0;
		cnt_wd  = cnt_inc;
		if (state_q == S_CALC) begin
			case (cmd_q.kind)
				K_OPEN: begin
					cs_we   = 1'b1;
					ct_we   = 1'b1;
					hash_we = new_q;
					cnt_we  = 1'b1;
				end
				K_PROG: begin
					ct_we = 1'b1;
				end
				K_CLOSE: begin
					cnt_we = 1'b1;
					cnt_wd = cnt_dec;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cs_we) begin
			cslot_mem[cid_ix] <= slot_q;
		end
		if (ct_we) begin
			csent_mem[cid_ix] <= (cmd_q.kind == K_OPEN) ? '0 : cmd_q.item.sent_total;
			ctime_mem[cid_ix] <= cmd_q.item.now_ms;
		end
		cslot_rd <= cslot_mem[cid_ix];
		csent_rd <= csent_mem[cid_ix];
		ctime_rd <= ctime_mem[cid_ix];
	end

	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[slot_q] <= cmd_q.item.flow_key;
		end
		hash_rd <= hash_mem[hash_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[slot_q] <= cnt_wd;
		end
		cnt_rd <= cnt_mem[slot_q];
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_CALC: begin
				div_num = DIV_NW'(rate);
				if (cmd_q.kind == K_OPEN) begin
					div_start = 1'b1;
					div_den   = DIV_DW'(cnt_inc);
				end else if (cmd_q.kind == K_PROG) begin
					div_start = 1'b1;
					div_den   = (cnt_eff == '0) ? DIV_DW'(1) : DIV_DW'(cnt_eff);
				end
			end
			S_WSHR: begin
				if (div_done && cmd_q.kind == K_PROG) begin
					if (delta_q > SENT_W'(share_n)) begin
						div_start = 1'b1;
						div_num   = dk_q;
						div_den   = share_n;
					end else if (elapsed_q != '0) begin
						div_start = 1'b1;
						div_num   = DIV_NW'(delta_q);
						div_den   = DIV_DW'(elapsed_q);
					end
				end
			end
			S_QCMP: begin
				if (qk_q > DIV_NW'(share_q)) begin
					div_start = 1'b1;
					div_num   = dk_q;
					div_den   = share_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			slot_q       <= '0;
			new_q        <= 1'b0;
			srch_idx_q   <= '0;
			cmp_pend_q   <= 1'b0;
			cmp_idx_q    <= '0;
			free_fnd_q   <= 1'b0;
			free_q       <= '0;
			delta_q      <= '0;
			elapsed_q    <= '0;
			share_q      <= '0;
			dk_q         <= '0;
			qk_q         <= '0;
			res_q        <= '0;
			done_q       <= 1'b0;
			conn_valid_q <= '0;
			key_valid_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.kind)
							K_PASS: begin
								res_q  <= mk(ST_OK, '0, '0);
								done_q <= 1'b1;
							end
							K_BADCID: begin
								res_q  <= mk(ST_UNKNOWN, '0, '0);
								done_q <= 1'b1;
							end
							default: state_q <= S_LOOK;
						endcase
					end
				end
				S_LOOK: state_q <= S_CONN;
				S_CONN: begin
					if (cmd_q.kind == K_OPEN) begin
						if (conn_valid_q[cid_ix]) begin
							res_q   <= mk(ST_BUSY, '0, '0);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							srch_idx_q <= '0;
							cmp_pend_q <= 1'b0;
							free_fnd_q <= 1'b0;
							state_q    <= S_SRCH;
						end
					end else if (!conn_valid_q[cid_ix]) begin
						res_q   <= mk(ST_UNKNOWN, '0, '0);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						slot_q  <= cslot_rd;
						new_q   <= 1'b0;
						state_q <= S_CNT;
					end
				end
				S_SRCH: begin
					cmp_pend_q <= (srch_idx_q < KIW'(KEY_SLOTS));
					cmp_idx_q  <= srch_idx_q[KW-1:0];
					if (srch_idx_q < KIW'(KEY_SLOTS)) begin
						srch_idx_q <= srch_idx_q + 1'b1;
					end
					if (cmp_pend_q) begin
						if (!free_fnd_q && !key_valid_q[cmp_idx_q]) begin
							free_fnd_q <= 1'b1;
							free_q     <= cmp_idx_q;
						end
						if (hit) begin
							slot_q  <= cmp_idx_q;
							new_q   <= 1'b0;
							state_q <= S_CNT;
						end else if (cmp_idx_q == KW'(KEY_SLOTS - 1)) begin
							if (free_any) begin
								slot_q  <= free_sel;
								new_q   <= 1'b1;
								state_q <= S_CNT;
							end else begin
								res_q   <= mk(ST_FULL, '0, '0);
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_CNT: state_q <= S_CALC;
				S_CALC: begin
					case (cmd_q.kind)
						K_OPEN: begin
							key_valid_q[slot_q]  <= 1'b1;
							conn_valid_q[cid_ix] <= 1'b1;
							state_q              <= S_WSHR;
						end
						K_PROG: begin
							delta_q   <= delta_n;
							elapsed_q <= cmd_q.item.now_ms - ctime_rd;
							state_q   <= S_WSHR;
						end
						default: begin
							conn_valid_q[cid_ix] <= 1'b0;
							if (cnt_dec == '0) begin
								key_valid_q[slot_q] <= 1'b0;
							end
							res_q   <= mk(ST_OK, '0, '0);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_WSHR: begin
					dk_q <= DIV_NW'(delta_q) * DIV_NW'(MS_PER_S);
					if (div_done) begin
						share_q <= share_n;
						if (cmd_q.kind == K_OPEN) begin
							res_q   <= mk(ST_OK, share_n, '0);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (delta_q > SENT_W'(share_n)) begin
							state_q <= S_WDLY;
						end else if (elapsed_q == '0) begin
							res_q   <= mk(ST_OK, share_n, IDLE_DELAY_MS);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_WQ;
						end
					end
				end
				S_WQ: begin
					if (div_done) begin
						qk_q    <= DIV_NW'(div_quo[SENT_W-1:0]) * DIV_NW'(MS_PER_S);
						state_q <= S_QCMP;
					end
				end
				S_QCMP: begin
					if (qk_q > DIV_NW'(share_q)) begin
						state_q <= S_WDLY;
					end else begin
						res_q   <= mk(ST_OK, share_q, '0);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_WDLY: begin
					if (div_done) begin
						res_q   <= mk(ST_OK, share_q, dly_n);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pop  = (state_q == S_IDLE) && cmd_valid;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

/* hw/rtl/per_key_shared_rate_shaper.sv */
// Channel   | Handshake                      | Beat
// command   | start / busy                   | item (in_t)
// result    | done, one cycle, no stall      | result (out_t)
// config    | psel penable pwrite pready     | paddr pwdata prdata, 64-bit
//
// One event at a time. Pass, bad-id and close events use no division; open
// runs a linear key search, then one share division; progress runs up to
// three serial divisions in the shared restoring divider. busy stays high
// until the result beat. Reset clears control state and valid bits; no
// clearing pass.
// Top level of the per-key shared rate shaper; depends on prks_pkg,
// prks_front, prks_fifo and prks_back.
module per_key_shared_rate_shaper import prks_pkg::*; #(
	parameter int KEY_SLOTS  = 64,
	parameter int CONN_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_t         item,
	output logic        done,
	output out_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic              enable_q;
	logic [RATE_W-1:0] rate_q;
	logic              accept;
	logic              fr_valid;
	cmd_t              fr_cmd;
	logic              fr_pop;
	cmd_t              q_cmd;
	fifo_stat_t        q_stat;
	logic              bk_pop;
	logic              bk_busy;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rate_q   <= RATE_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[3] == REG_ENABLE) begin
				enable_q <= pwdata[0];
			end else begin
				rate_q <= pwdata[RATE_W-1:0];
			end
		end
	end

	assign prdata = (paddr[3] == REG_RATE) ? 64'(rate_q) : 64'(enable_q);

	assign accept = start && !busy;
	assign fr_pop = fr_valid && !q_stat.full;
	assign busy   = fr_valid || !q_stat.empty || bk_busy;

	prks_front #(.CONN_SLOTS(CONN_SLOTS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.enable (enable_q),
		.pop    (fr_pop),
		.valid  (fr_valid),
		.cmd    (fr_cmd)
	);

	prks_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_pop),
		.wdata  (fr_cmd),
		.pop    (bk_pop),
		.rdata  (q_cmd),
		.stat   (q_stat)
	);

	prks_back #(.KEY_SLOTS(KEY_SLOTS), .CONN_SLOTS(CONN_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rate      (rate_q),
		.cmd_valid (!q_stat.empty),
		.cmd       (q_cmd),
		.pop       (bk_pop),
		.busy      (bk_busy),
		.done      (done),
		.res       (result)
	);

endmodule

/* hw/rtl/prks_checker.sv */
// Port-level checks for the per-key shared rate shaper, bound to the top.
// Depends on prks_pkg.
module prks_checker import prks_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in a row");

	a_delay_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.delayed == (result.delay_ms != 32'd0)))
		else $error("delayed flag and delay_ms disagree");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |->
			result.chunk_limit == '0 && !result.delayed)
		else $error("error result carries payload");

endmodule

bind per_key_shared_rate_shaper prks_checker u_chk (.*);

/* tb/per_key_shared_rate_shaper_tb.sv */
// Testbench for per_key_shared_rate_shaper: directed and random events against
// an in-bench model of the key and connection tables; depends on prks_pkg.
`timescale 1ns / 1ps
module per_key_shared_rate_shaper_tb;
	import prks_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         item;
	logic        done;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	per_key_shared_rate_shaper i_dut (.*);

	// shadow of the block's tables
	logic              m_enable;
	logic [39:0]       m_rate;
	logic [31:0]       m_key_hash[64];
	logic              m_key_valid[64];
	logic [8:0]        m_key_cnt[64];
	logic              m_conn_valid[256];
	logic [5:0]        m_conn_slot[256];
	logic [47:0]       m_conn_sent[256];
	logic [31:0]       m_conn_time[256];

	in_t  pending_events[$];
	out_t expected_answers[$];
	int   errors;
	bit   no_gaps;

	// generator-side view of connection state
	bit          g_open[256];
	logic [47:0] g_sent[256];
	logic [31:0] g_now;
	logic [31:0] key_pool[128];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	function automatic logic [39:0] share_for(input int slot);
		logic [39:0] cnt, s;
		cnt = (m_key_cnt[slot] == 0) ? 40'd1 : 40'(m_key_cnt[slot]);
		s = m_rate / cnt;
		return (s == 0) ? 40'd1 : s;
	endfunction

	function automatic logic [31:0] scaled_delay(input logic [63:0] delta, input logic [39:0] sh);
		logic [63:0] d;
		d = (delta * 64'd1000) / 64'(sh);
		return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
	endfunction

	function automatic out_t shaper_answer(input in_t ev);
		out_t r;
		int i, slot, free_slot;
		int c;
		logic [39:0] sh;
		logic [63:0] delta;
		logic [31:0] elapsed, d;
		r = '0;
		c = ev.conn_id;
		if (!m_enable || ev.req_type == 2'd3) begin
		end else if (ev.req_type == REQ_OPEN) begin
			if (m_conn_valid[c]) begin
				r.status = ST_BUSY;
			end else begin
				slot = 64;
				free_slot = 64;
				for (i = 0; i < 64; i++) begin
					if (m_key_valid[i] && m_key_hash[i] == ev.flow_key) begin
						slot = i;
						break;
					end
					if (!m_key_valid[i] && free_slot == 64) free_slot = i;
				end
				if (slot == 64 && free_slot == 64) begin
					r.status = ST_FULL;
				end else begin
					if (slot == 64) begin
						slot = free_slot;
						m_key_valid[slot] = 1;
						m_key_hash[slot] = ev.flow_key;
						m_key_cnt[slot] = 0;
					end
					if (m_key_cnt[slot] < CNT_MAX) m_key_cnt[slot]++;
					m_conn_valid[c] = 1;
					m_conn_slot[c] = slot[5:0];
					m_conn_sent[c] = 0;
					m_conn_time[c] = ev.now_ms;
					r.chunk_limit = share_for(slot);
				end
			end
		end else if (!m_conn_valid[c]) begin
			r.status = ST_UNKNOWN;
		end else if (ev.req_type == REQ_PROG) begin
			slot = m_conn_slot[c];
			sh = share_for(slot);
			delta = (ev.sent_total >= m_conn_sent[c]) ? 64'(ev.sent_total - m_conn_sent[c]) : 64'd0;
			elapsed = ev.now_ms - m_conn_time[c];
			m_conn_sent[c] = ev.sent_total;
			m_conn_time[c] = ev.now_ms;
			r.chunk_limit = sh;
			d = 0;
			if (delta > 64'(sh)) d = scaled_delay(delta, sh);
			else if (elapsed == 0) d = IDLE_DELAY_MS;
			else if ((delta / 64'(elapsed)) * 64'd1000 > 64'(sh)) d = scaled_delay(delta, sh);
			if (d != 0) begin
				r.delayed = 1;
				r.delay_ms = d;
			end
		end else begin
			slot = m_conn_slot[c];
			m_conn_valid[c] = 0;
			if (m_key_cnt[slot] > 0) m_key_cnt[slot]--;
			if (m_key_cnt[slot] == 0) m_key_valid[slot] = 0;
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_answers.push_back(shaper_answer(item));
				void'(pending_events.pop_front());
				if (pending_events.size() > 0 && (no_gaps || $urandom_range(99) >= 32)) begin
					item <= pending_events[0];
				end else begin
					start <= 0;
				end
			end else if (!start && pending_events.size() > 0
					&& (no_gaps || $urandom_range(99) >= 32)) begin
				start <= 1;
				item <= pending_events[0];
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// monitor
	always @(posedge clk) begin
		out_t e;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected beat", 64'(result.status), 64'd0);
			end else begin
				e = expected_answers.pop_front();
				if (result.status !== e.status)
					report_mismatch("status", 64'(result.status), 64'(e.status));
				if (result.chunk_limit !== e.chunk_limit)
					report_mismatch("chunk_limit", 64'(result.chunk_limit), 64'(e.chunk_limit));
				if (result.delayed !== e.delayed)
					report_mismatch("delayed", 64'(result.delayed), 64'(e.delayed));
				if (result.delay_ms !== e.delay_ms)
					report_mismatch("delay_ms", 64'(result.delay_ms), 64'(e.delay_ms));
			end
		end
	end

	task automatic reg_write(input logic reg_idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {reg_idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (reg_idx == REG_ENABLE) m_enable = val[0];
		else m_rate = val[39:0];
	endtask

	task automatic drain;
		while (pending_events.size() > 0 || expected_answers.size() > 0 || busy || start)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_t make_event(input logic [1:0] t, input logic [31:0] k,
			input int c, input logic [47:0] s, input logic [31:0] n);
		in_t ev;
		ev.req_type = t;
		ev.flow_key = k;
		ev.conn_id = c[7:0];
		ev.sent_total = s;
		ev.now_ms = n;
		return ev;
	endfunction

	function automatic int pick_conn(input bit want_open);
		int c;
		for (int i = 0; i < 6; i++) begin
			c = $urandom_range(255);
			if (g_open[c] == want_open) return c;
		end
		return c;
	endfunction

	task automatic random_events(input int n, input int open_pct, input int pool);
		int r, c;
		logic [1:0] t;
		logic [47:0] s;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			case ($urandom_range(9))
				0: ;
				1, 2: g_now += $urandom_range(3);
				default: g_now += $urandom_range(2000);
			endcase
			s = '0;
			if (r < open_pct) begin
				t = REQ_OPEN;
				c = pick_conn(0);
				g_open[c] = 1;
				g_sent[c] = 0;
			end else if (r < open_pct + (100 - open_pct) * 3 / 4) begin
				t = REQ_PROG;
				c = pick_conn(1);
				case ($urandom_range(7))
					0: s = 48'({$urandom, $urandom});
					1: s = g_sent[c] - $urandom_range(500);
					2: s = g_sent[c] + 48'({$urandom, $urandom} % 64'h100_0000_0000);
					3: s = g_sent[c] + $urandom;
					default: s = g_sent[c] + $urandom_range(20000);
				endcase
				g_sent[c] = s;
			end else if (r < 97) begin
				t = REQ_CLOSE;
				c = pick_conn(1);
				g_open[c] = 0;
			end else begin
				t = 2'd3;
				c = $urandom_range(255);
				s = 48'({$urandom, $urandom});
			end
			pending_events.push_back(make_event(t, key_pool[$urandom_range(pool - 1)], c, s, g_now));
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		item = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		no_gaps = 0;
		m_enable = 0;
		m_rate = RATE_RESET;
		g_now = 32'hFFFF_F000;
		for (int i = 0; i < 64; i++) begin
			m_key_valid[i] = 0;
			m_key_cnt[i] = 0;
		end
		for (int i = 0; i < 256; i++) begin
			m_conn_valid[i] = 0;
			g_open[i] = 0;
			g_sent[i] = 0;
		end
		for (int i = 0; i < 128; i++) key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// disabled at reset: pass through
		pending_events.push_back(make_event(REQ_OPEN, 32'h1234, 3, 48'h0, 32'd5));
		pending_events.push_back(make_event(REQ_PROG, 32'hFFFF_FFFF, 255, '1, '1));
		drain();

		reg_write(REG_ENABLE, 64'd1);
		pending_events.push_back(make_event(REQ_OPEN, 32'h0, 0, 48'h0, 32'd1000));
		pending_events.push_back(make_event(REQ_OPEN, 32'h0, 1, 48'h0, 32'd1000));
		pending_events.push_back(make_event(REQ_OPEN, 32'h5, 0, 48'h0, 32'd1000));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 0, 48'd2000000, 32'd1010));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 0, 48'd2000010, 32'd1010));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 0, 48'd5, 32'd1500));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 1, 48'd100, 32'd6000));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 1, 48'd600000, 32'd6001));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 7, 48'd1, 32'd1));
		pending_events.push_back(make_event(REQ_CLOSE, 32'h0, 9, 48'd1, 32'd1));
		pending_events.push_back(make_event(2'd3, 32'hFFFF_FFFF, 255, '1, '1));
		pending_events.push_back(make_event(REQ_OPEN, 32'hFFFF_FFFF, 255, '1, 32'hFFFF_FFFF));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 255, '1, 32'd3));
		pending_events.push_back(make_event(REQ_CLOSE, 32'h0, 0, 48'h0, 32'd0));
		pending_events.push_back(make_event(REQ_CLOSE, 32'h0, 1, 48'h0, 32'd0));
		pending_events.push_back(make_event(REQ_CLOSE, 32'h0, 255, 48'h0, 32'd0));
		pending_events.push_back(make_event(REQ_PROG, 32'h0, 0, 48'h0, 32'd0));
		drain();

		reg_write(REG_RATE, 64'd1);
		pending_events.push_back(make_event(REQ_OPEN, 32'hA, 10, 48'h0, 32'd0));
		pending_events.push_back(make_event(REQ_OPEN, 32'hA, 11, 48'h0, 32'd0));
		pending_events.push_back(make_event(REQ_PROG, 32'hA, 10, 48'h0, 32'd7));
		pending_events.push_back(make_event(REQ_PROG, 32'hA, 11, '1, 32'd9));
		drain();
		reg_write(REG_RATE, 64'hFF_FFFF_FFFF);
		pending_events.push_back(make_event(REQ_PROG, 32'hA, 10, 48'd1, 32'd8));
		pending_events.push_back(make_event(REQ_PROG, 32'hA, 10, '1, 32'd9));
		drain();

		// fill the tables: many keys, mostly opens
		reg_write(REG_RATE, 64'd1048576);
		random_events(300, 60, 128);
		drain();
		no_gaps = 1;
		reg_write(REG_RATE, 64'd3000);
		random_events(250, 30, 20);
		drain();
		no_gaps = 0;
		reg_write(REG_RATE, 64'hFF_FFFF_FFFF);
		random_events(200, 35, 80);
		drain();
		reg_write(REG_ENABLE, 64'd0);
		random_events(60, 35, 80);
		drain();
		reg_write(REG_ENABLE, 64'd1);
		reg_write(REG_RATE, 64'd1);
		random_events(150, 35, 40);
		drain();
		reg_write(REG_RATE, 64'd250000);
		random_events(320, 40, 100);
		drain();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
